@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define AEC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define AEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/aec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aec_pkg;

    localparam int MAX_CHARS_DEF = 1024;
    localparam int MIN_CHARS     = 5;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // parse phases
    localparam logic [2:0] PH_LEFT0  = 3'd0;
    localparam logic [2:0] PH_LEFT   = 3'd1;
    localparam logic [2:0] PH_RIGHT0 = 3'd2;
    localparam logic [2:0] PH_RIGHT  = 3'd3;
    localparam logic [2:0] PH_SIGN   = 3'd4;
    localparam logic [2:0] PH_ANS0   = 3'd5;
    localparam logic [2:0] PH_ANS    = 3'd6;

    // operators
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // verdicts
    localparam logic [3:0] STAT_CORRECT   = 4'd0;
    localparam logic [3:0] STAT_WRONG     = 4'd1;
    localparam logic [3:0] STAT_SHORT     = 4'd2;
    localparam logic [3:0] STAT_BAD_LEFT  = 4'd3;
    localparam logic [3:0] STAT_BAD_OP    = 4'd4;
    localparam logic [3:0] STAT_BAD_RIGHT = 4'd5;
    localparam logic [3:0] STAT_BAD_EQ    = 4'd6;
    localparam logic [3:0] STAT_BAD_ANS   = 4'd7;
    localparam logic [3:0] STAT_BAD_TAIL  = 4'd8;
    localparam logic [3:0] STAT_BAD_DIV   = 4'd9;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } symbol_req_t;

    typedef struct packed {
        logic [3:0]         status;
        logic [30:0]        left_value;
        logic [30:0]        right_value;
        logic signed [31:0] given_answer;
        logic signed [31:0] expected_answer;
        logic [1:0]         operator_code;
        logic [9:0]         answer_start;
        logic [10:0]        answer_length;
        logic               overflow;
    } verdict_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] left_acc;
        logic [31:0] right_acc;
        logic [31:0] answer_acc;
        logic        answer_negative;
        logic [1:0]  op_held;
        logic        error_seen;
        logic [3:0]  error_code;
        logic        overflow_seen;
    } parse_state_t;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] value;
        logic        overflow;
        logic        inexact;
    } md_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/aec_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aec_parser #(
    parameter int MAX_CHARS = aec_pkg::MAX_CHARS_DEF,
    localparam int CW = $clog2(MAX_CHARS + 1),
    localparam int IW = $clog2(MAX_CHARS + 2)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic                  clear,
    input  wire logic [7:0]            symbol,
    output aec_pkg::parse_state_t      ps,
    output logic [CW-1:0]              char_count,
    output logic [IW-1:0]              answer_index
);

    aec_pkg::parse_state_t ps_reg, ps_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] index_reg, index_next;

    logic        is_dig;
    logic [3:0]  digit;
    logic [31:0] acc_sel;
    logic [35:0] push;
    logic        push_ovf;

    always_comb begin
        is_dig = symbol inside {[aec_pkg::CH_0:aec_pkg::CH_9]};
        digit  = 4'(symbol - aec_pkg::CH_0);
        if (ps_reg.phase inside {aec_pkg::PH_LEFT0, aec_pkg::PH_LEFT}) begin
            acc_sel = ps_reg.left_acc;
        end else if (ps_reg.phase inside {aec_pkg::PH_RIGHT0, aec_pkg::PH_RIGHT}) begin
            acc_sel = ps_reg.right_acc;
        end else begin
            acc_sel = ps_reg.answer_acc;
        end
        // acc * 10 + digit
        push     = (36'(acc_sel) << 3) + (36'(acc_sel) << 1) + 36'(digit);
        push_ovf = |push[35:31];
    end

    always_comb begin
        ps_next    = ps_reg;
        count_next = count_reg;
        index_next = index_reg;
        if (clear) begin
            ps_next    = '0;
            count_next = '0;
            index_next = '0;
        end else if (step) begin
            if (count_reg < CW'(MAX_CHARS)) begin
                count_next = count_reg + 1'b1;
            end
            if (!ps_reg.error_seen) begin
                case (ps_reg.phase)
                    aec_pkg::PH_LEFT0: begin
                        if (is_dig) begin
                            ps_next.left_acc      = push[31:0];
                            ps_next.overflow_seen = ps_reg.overflow_seen | push_ovf;
                            ps_next.phase         = aec_pkg::PH_LEFT;
                        end else begin
                            ps_next.error_seen = 1'b1;
                            ps_next.error_code = aec_pkg::STAT_BAD_LEFT;
                        end
                    end
                    aec_pkg::PH_LEFT: begin
                        if (is_dig) begin
                            ps_next.left_acc      = push[31:0];
                            ps_next.overflow_seen = ps_reg.overflow_seen | push_ovf;
                        end else if (symbol == aec_pkg::CH_PLUS) begin
                            ps_next.op_held = aec_pkg::OP_ADD;
                            ps_next.phase   = aec_pkg::PH_RIGHT0;
                        end else if (symbol == aec_pkg::CH_MINUS) begin
                            ps_next.op_held = aec_pkg::OP_SUB;
                            ps_next.phase   = aec_pkg::PH_RIGHT0;
                        end else if (symbol == aec_pkg::CH_STAR) begin
                            ps_next.op_held = aec_pkg::OP_MUL;
                            ps_next.phase   = aec_pkg::PH_RIGHT0;
                        end else if (symbol == aec_pkg::CH_SLASH) begin
                            ps_next.op_held = aec_pkg::OP_DIV;
                            ps_next.phase   = aec_pkg::PH_RIGHT0;
                        end else begin
                            ps_next.error_seen = 1'b1;
                            ps_next.error_code = aec_pkg::STAT_BAD_OP;
                        end
                    end
                    aec_pkg::PH_RIGHT0: begin
                        if (is_dig) begin
                            ps_next.right_acc     = push[31:0];
                            ps_next.overflow_seen = ps_reg.overflow_seen | push_ovf;
                            ps_next.phase         = aec_pkg::PH_RIGHT;
                        end else begin
                            ps_next.error_seen = 1'b1;
                            ps_next.error_code = aec_pkg::STAT_BAD_RIGHT;
                        end
                    end
                    aec_pkg::PH_RIGHT: begin
                        if (is_dig) begin
                            ps_next.right_acc     = push[31:0];
                            ps_next.overflow_seen = ps_reg.overflow_seen | push_ovf;
                        end else if (symbol == aec_pkg::CH_EQ) begin
                            index_next    = IW'(count_reg) + IW'(1);
                            ps_next.phase = aec_pkg::PH_SIGN;
                        end else begin
                            ps_next.error_seen = 1'b1;
                            ps_next.error_code = aec_pkg::STAT_BAD_EQ;
                        end
                    end
                    aec_pkg::PH_SIGN: begin
                        if (symbol == aec_pkg::CH_MINUS) begin
                            ps_next.answer_negative = 1'b1;
                            ps_next.phase           = aec_pkg::PH_ANS0;
                        end else if (is_dig) begin
                            ps_next.answer_acc    = push[31:0];
                            ps_next.overflow_seen = ps_reg.overflow_seen | push_ovf;
                            ps_next.phase         = aec_pkg::PH_ANS;
                        end else begin
                            ps_next.error_seen = 1'b1;
                            ps_next.error_code = aec_pkg::STAT_BAD_ANS;
                        end
                    end
                    aec_pkg::PH_ANS0: begin
                        if (is_dig) begin
                            ps_next.answer_acc    = push[31:0];
                            ps_next.overflow_seen = ps_reg.overflow_seen | push_ovf;
                            ps_next.phase         = aec_pkg::PH_ANS;
                        end else begin
                            ps_next.error_seen = 1'b1;
                            ps_next.error_code = aec_pkg::STAT_BAD_ANS;
                        end
                    end
                    default: begin
                        if (is_dig) begin
                            ps_next.answer_acc    = push[31:0];
                            ps_next.overflow_seen = ps_reg.overflow_seen | push_ovf;
                        end else begin
                            ps_next.error_seen = 1'b1;
                            ps_next.error_code = aec_pkg::STAT_BAD_TAIL;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg    <= '0;
            count_reg <= '0;
            index_reg <= '0;
        end else begin
            ps_reg    <= ps_next;
            count_reg <= count_next;
            index_reg <= index_next;
        end
    end

    assign ps           = ps_reg;
    assign char_count   = count_reg;
    assign answer_index = index_reg;

endmodule

`default_nettype wire

@@ rtl/core/aec_muldiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Signed 32-bit multiply / exact-divide check on one shared 33-bit
// add/subtract unit, one bit per cycle.
module aec_muldiv (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  aec_pkg::md_req_t      md_req,
    output aec_pkg::md_rsp_t      md_rsp
);

    localparam int ITERS = 32;
    localparam int IT_W  = $clog2(ITERS);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_FIX  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [IT_W-1:0] iter_reg, iter_next;
    logic            div_reg, div_next;
    logic            neg_reg, neg_next;
    logic [31:0]     hi_reg, hi_next;
    logic [31:0]     lo_reg, lo_next;
    logic [31:0]     opnd_reg, opnd_next;

    logic [31:0] abs_a, abs_b;
    logic [32:0] alu_x, alu_y;
    logic        alu_sub;
    logic [33:0] alu_res;

    always_comb begin
        abs_a = md_req.a[31] ? 32'd0 - md_req.a : md_req.a;
        abs_b = md_req.b[31] ? 32'd0 - md_req.b : md_req.b;
        if (div_reg) begin
            alu_x   = {hi_reg, lo_reg[31]};
            alu_y   = {1'b0, opnd_reg};
            alu_sub = 1'b1;
        end else begin
            alu_x   = {1'b0, hi_reg};
            alu_y   = lo_reg[0] ? {1'b0, opnd_reg} : 33'd0;
            alu_sub = 1'b0;
        end
        // carry out is "no borrow" on subtract
        alu_res = {1'b0, alu_x} + {1'b0, alu_sub ? ~alu_y : alu_y} + 34'(alu_sub);
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        opnd_next  = opnd_reg;
        case (state_reg)
            M_IDLE: begin
                if (md_req.start) begin
                    state_next = M_RUN;
                    iter_next  = '0;
                    div_next   = md_req.is_div;
                    neg_next   = md_req.a[31] ^ md_req.b[31];
                    hi_next    = '0;
                    lo_next    = md_req.is_div ? abs_a : abs_b;
                    opnd_next  = md_req.is_div ? abs_b : abs_a;
                end
            end
            M_RUN: begin
                if (div_reg) begin
                    hi_next = alu_res[33] ? alu_res[31:0] : alu_x[31:0];
                    lo_next = {lo_reg[30:0], alu_res[33]};
                end else begin
                    hi_next = alu_res[32:1];
                    lo_next = {alu_res[0], lo_reg[31:1]};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == IT_W'(ITERS - 1)) begin
                    state_next = M_FIX;
                end
            end
            M_FIX: begin
                state_next = M_IDLE;
            end
            default: begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        opnd_reg <= opnd_next;
    end

    // product magnitude is {hi, lo}; quotient lo, remainder hi
    always_comb begin
        md_rsp.busy     = (state_reg != M_IDLE);
        md_rsp.done     = (state_reg == M_FIX);
        md_rsp.value    = neg_reg ? 32'd0 - lo_reg : lo_reg;
        md_rsp.overflow = !div_reg && ((hi_reg != 32'd0) ||
                          (lo_reg[31] && (!neg_reg || (lo_reg[30:0] != 31'd0))));
        md_rsp.inexact  = div_reg && (hi_reg != 32'd0);
    end

    `AEC_ASSERT(a_md_start_idle, aclk, aresetn, md_req.start |-> !md_rsp.busy, "start while busy")
    `AEC_ASSERT(a_md_done_once, aclk, aresetn, md_rsp.done |=> !md_rsp.busy, "unit stuck after done")

endmodule

`default_nettype wire

@@ rtl/core/arith_equation_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Checks a written equation "digits op digits = [-]digits", one ASCII
// character per request on the s_ channel (s_data.last_symbol marks the end).
// Each string yields exactly one verdict request on the m_ channel.
// Flow: a non-final character is taken without dropping s_ready. After the
// final character the sequencer steps through S_EVAL and S_DONE, and the verdict
// is then moved into the output register; multiply, and divide by a nonzero
// divisor, also pass through S_CALC, where the shared unit resolves one
// product/quotient bit per cycle (32 iterations plus setup and sign fixup).
// s_ready is low from the final character until the verdict has been moved
// into the output register. The output register lets a new string start while
// the verdict waits; if the receiver stalls, the next verdict waits until the
// register frees up, holding s_ready low meanwhile.
// Reset (aresetn low, synchronous) clears the parse state and drops m_valid.
// Parse state clears itself after each verdict.
module arith_equation_checker #(
    parameter int MAX_CHARS = aec_pkg::MAX_CHARS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  aec_pkg::symbol_req_t       s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output aec_pkg::verdict_t          m_data
);

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int IW = $clog2(MAX_CHARS + 2);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  status_reg, status_next;
    logic        cmp_reg, cmp_next;       // verdict is correct/wrong, decided at the end
    logic [31:0] expected_reg, expected_next;
    logic        mul_ovf_reg, mul_ovf_next;
    logic        m_valid_reg, m_valid_next;
    aec_pkg::verdict_t m_data_reg, m_data_next;

    aec_pkg::parse_state_t ps;
    logic [CW-1:0] char_count;
    logic [IW-1:0] answer_index;
    aec_pkg::md_req_t md_req;
    aec_pkg::md_rsp_t md_rsp;

    logic        accept;
    logic        clear;
    logic        out_free;
    logic [31:0] given;
    logic [3:0]  final_status;
    logic [31:0] idx32, cnt32, len32;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign clear   = (state_reg == S_DONE) && out_free;

    aec_parser #(
        .MAX_CHARS(MAX_CHARS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .clear       (clear),
        .symbol      (s_data.symbol),
        .ps          (ps),
        .char_count  (char_count),
        .answer_index(answer_index)
    );

    aec_muldiv u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .md_req (md_req),
        .md_rsp (md_rsp)
    );

    always_comb begin
        given        = ps.answer_negative ? 32'd0 - ps.answer_acc : ps.answer_acc;
        final_status = cmp_reg ? ((given == expected_reg) ? aec_pkg::STAT_CORRECT
                                                          : aec_pkg::STAT_WRONG)
                               : status_reg;
        idx32 = 32'(answer_index);
        cnt32 = 32'(char_count);
        len32 = cnt32 - idx32;
    end

    always_comb begin
        state_next    = state_reg;
        status_next   = status_reg;
        cmp_next      = cmp_reg;
        expected_next = expected_reg;
        mul_ovf_next  = mul_ovf_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        m_data_next   = m_data_reg;
        md_req.start  = 1'b0;
        md_req.is_div = (ps.op_held == aec_pkg::OP_DIV);
        md_req.a      = ps.left_acc;
        md_req.b      = ps.right_acc;

        case (state_reg)
            S_IDLE: begin
                if (accept && s_data.last_symbol) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next    = S_DONE;
                cmp_next      = 1'b0;
                expected_next = '0;
                mul_ovf_next  = 1'b0;
                if (char_count < CW'(aec_pkg::MIN_CHARS)) begin
                    status_next = aec_pkg::STAT_SHORT;
                end else if (ps.error_seen) begin
                    status_next = ps.error_code;
                end else if (ps.phase != aec_pkg::PH_ANS) begin
                    // string ended while still expecting an element
                    if (ps.phase inside {aec_pkg::PH_LEFT0, aec_pkg::PH_LEFT}) begin
                        status_next = aec_pkg::STAT_BAD_OP;
                    end else if (ps.phase == aec_pkg::PH_RIGHT0) begin
                        status_next = aec_pkg::STAT_BAD_RIGHT;
                    end else if (ps.phase == aec_pkg::PH_RIGHT) begin
                        status_next = aec_pkg::STAT_BAD_EQ;
                    end else begin
                        status_next = aec_pkg::STAT_BAD_ANS;
                    end
                end else begin
                    case (ps.op_held)
                        aec_pkg::OP_ADD: begin
                            expected_next = ps.left_acc + ps.right_acc;
                            cmp_next      = 1'b1;
                        end
                        aec_pkg::OP_SUB: begin
                            expected_next = ps.left_acc - ps.right_acc;
                            cmp_next      = 1'b1;
                        end
                        aec_pkg::OP_MUL: begin
                            md_req.start = 1'b1;
                            state_next   = S_CALC;
                        end
                        default: begin
                            if (ps.right_acc == 32'd0) begin
                                status_next = aec_pkg::STAT_BAD_DIV;
                            end else begin
                                md_req.start = 1'b1;
                                state_next   = S_CALC;
                            end
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (md_rsp.done) begin
                    state_next = S_DONE;
                    if (md_rsp.inexact) begin
                        status_next = aec_pkg::STAT_BAD_DIV;
                    end else begin
                        expected_next = md_rsp.value;
                        mul_ovf_next  = md_rsp.overflow;
                        cmp_next      = 1'b1;
                    end
                end
            end
            default: begin
                // S_DONE: move the verdict to the output register once it is free
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next.status = final_status;
                    if (cmp_reg) begin
                        m_data_next.left_value      = ps.left_acc[30:0];
                        m_data_next.right_value     = ps.right_acc[30:0];
                        m_data_next.given_answer    = given;
                        m_data_next.expected_answer = expected_reg;
                        m_data_next.operator_code   = ps.op_held;
                        m_data_next.answer_start    = idx32[9:0];
                        m_data_next.answer_length   = len32[10:0];
                        m_data_next.overflow        = ps.overflow_seen | mul_ovf_reg;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            cmp_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cmp_reg     <= cmp_next;
        end
        status_reg   <= status_next;
        expected_reg <= expected_next;
        mul_ovf_reg  <= mul_ovf_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `AEC_ASSERT(a_last_to_eval, aclk, aresetn, (accept && s_data.last_symbol) |=> (state_reg == S_EVAL), "final character not evaluated")
    `AEC_ASSERT(a_load_from_done, aclk, aresetn, $rose(m_valid) |-> $past(state_reg == S_DONE), "verdict loaded outside done")
    `AEC_ASSERT(a_error_zero, aclk, aresetn, m_valid |-> ((m_data.status == aec_pkg::STAT_CORRECT) || (m_data.status == aec_pkg::STAT_WRONG) || ((m_data.overflow == 1'b0) && (m_data.left_value == 31'd0) && (m_data.expected_answer == 32'sd0))), "error verdict carries values")
    `AEC_ASSERT_ALWAYS(a_reset_drops_valid, aclk, !aresetn |=> !m_valid, "m_valid survives reset")

endmodule

`default_nettype wire

@@ verif/arith_equation_checker_test.sv @@
`timescale 1ns / 1ps

// Testbench for arith_equation_checker.
// Strings go in one character per request on the s_ channel. Exactly one
// verdict request per string comes back on the m_ channel.
// A local parser/evaluator predicts every verdict. Predictions queue up in
// order and each verdict taken on m_ is checked against the oldest one.
// Stimulus plan:
//   - a directed table of whole strings, walked in order. Error rows carry a
//     hand-written verdict; arithmetic rows rely on the predictor.
//   - random strings: mostly well-formed equations (answers right, near-miss or
//     wrong), some with one character damaged, cut short or inserted, some pure
//     noise.
// Both sides insert bubbles at random, with one long stretch of full rate.
// The sender also stops three times until the verdict queue has drained.
module arith_equation_checker_test;
    import aec_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_CHARS  = 1350;
    localparam int SHOW_FAULTS   = 10;
    localparam longint PROD_MAX  = 64'sd2147483647;
    localparam longint PROD_MIN  = -64'sd2147483648;

    typedef logic [7:0] text_t[$];

    // one directed string; typed rows carry their verdict written out by hand
    typedef struct {
        string    text;
        bit       typed;
        verdict_t verdict;
    } case_row_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    symbol_req_t s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    verdict_t    m_data;

    arith_equation_checker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: mirrors the parse state of the block
    // ------------------------------------------------------------------
    logic [2:0]  eq_phase;
    int unsigned eq_count;          // saturates at MAX_CHARS_DEF
    logic [31:0] lhs_acc;
    logic [31:0] rhs_acc;
    logic [31:0] ans_acc;
    logic        ans_neg;
    logic [1:0]  op_seen;
    logic [31:0] ans_pos;           // full width; masked only when reported
    logic        fault_seen;
    logic [3:0]  fault_code;
    logic        wide_seen;         // a number or the product left int32 range

    verdict_t    verdicts_due[$];   // predicted verdicts, oldest first
    case_row_t   dir_cases[$];

    int          send_idle_pct = 37;
    int          stall_pct     = 37;
    int          cycle_count   = 0;
    int          fault_count   = 0;
    int          verdicts_seen = 0;
    int          strings_sent  = 0;
    int          chars_sent    = 0;
    int          status_hits[16];

    function automatic void clear_parse();
        eq_phase   = PH_LEFT0;
        eq_count   = 0;
        lhs_acc    = '0;
        rhs_acc    = '0;
        ans_acc    = '0;
        ans_neg    = 1'b0;
        op_seen    = OP_ADD;
        ans_pos    = '0;
        fault_seen = 1'b0;
        fault_code = STAT_CORRECT;
        wide_seen  = 1'b0;
    endfunction

    // acc*10 + digit, wrapping at 32 bits; past int32 max sets the overflow flag
    function automatic logic [31:0] shift_digit(input logic [31:0] acc, input logic [7:0] c);
        logic [63:0] v;
        v = 64'(acc) * 64'd10 + 64'(c - CH_0);
        if (v > 64'h7FFF_FFFF) wide_seen = 1'b1;
        return v[31:0];
    endfunction

    // only the first parse error of a string is kept
    function automatic void flag_fault(input logic [3:0] code);
        if (!fault_seen) begin
            fault_seen = 1'b1;
            fault_code = code;
        end
    endfunction

    // Consumes one character; returns 1 with the verdict on the final one.
    function automatic bit judge_symbol(input symbol_req_t r, output verdict_t v);
        logic [7:0]  c;
        logic        dig;
        logic [31:0] pos;
        logic [31:0] calc;
        logic [31:0] given;
        logic [3:0]  status;
        longint      sa;
        longint      sb;
        longint      prod;
        c      = r.symbol;
        dig    = (c >= CH_0) && (c <= CH_9);
        pos    = eq_count;
        v      = '0;
        calc   = '0;
        given  = '0;
        status = STAT_CORRECT;
        if (eq_count < MAX_CHARS_DEF) eq_count++;

        if (!fault_seen) begin
            case (eq_phase)
                PH_LEFT0: begin
                    if (dig) begin
                        lhs_acc  = shift_digit(lhs_acc, c);
                        eq_phase = PH_LEFT;
                    end else begin
                        flag_fault(STAT_BAD_LEFT);
                    end
                end
                PH_LEFT: begin
                    if (dig) begin
                        lhs_acc = shift_digit(lhs_acc, c);
                    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR
                                 || c == CH_SLASH) begin
                        op_seen  = (c == CH_PLUS)  ? OP_ADD :
                                   (c == CH_MINUS) ? OP_SUB :
                                   (c == CH_STAR)  ? OP_MUL : OP_DIV;
                        eq_phase = PH_RIGHT0;
                    end else begin
                        flag_fault(STAT_BAD_OP);
                    end
                end
                PH_RIGHT0: begin
                    if (dig) begin
                        rhs_acc  = shift_digit(rhs_acc, c);
                        eq_phase = PH_RIGHT;
                    end else begin
                        flag_fault(STAT_BAD_RIGHT);
                    end
                end
                PH_RIGHT: begin
                    if (dig) begin
                        rhs_acc = shift_digit(rhs_acc, c);
                    end else if (c == CH_EQ) begin
                        ans_pos  = pos + 1;
                        eq_phase = PH_SIGN;
                    end else begin
                        flag_fault(STAT_BAD_EQ);
                    end
                end
                PH_SIGN: begin
                    if (c == CH_MINUS) begin
                        ans_neg  = 1'b1;
                        eq_phase = PH_ANS0;
                    end else if (dig) begin
                        ans_acc  = shift_digit(ans_acc, c);
                        eq_phase = PH_ANS;
                    end else begin
                        flag_fault(STAT_BAD_ANS);
                    end
                end
                PH_ANS0: begin
                    if (dig) begin
                        ans_acc  = shift_digit(ans_acc, c);
                        eq_phase = PH_ANS;
                    end else begin
                        flag_fault(STAT_BAD_ANS);
                    end
                end
                default: begin
                    if (dig) ans_acc = shift_digit(ans_acc, c);
                    else flag_fault(STAT_BAD_TAIL);
                end
            endcase
        end

        if (!r.last_symbol) return 0;

        // too short wins over any parse error
        if (eq_count < MIN_CHARS) begin
            status = STAT_SHORT;
        end else if (fault_seen) begin
            status = fault_code;
        end else if (eq_phase != PH_ANS) begin
            // string ended while an element was still missing
            case (eq_phase)
                PH_LEFT0, PH_LEFT: status = STAT_BAD_OP;
                PH_RIGHT0:         status = STAT_BAD_RIGHT;
                PH_RIGHT:          status = STAT_BAD_EQ;
                default:           status = STAT_BAD_ANS;
            endcase
        end else begin
            sa = longint'($signed(lhs_acc));
            sb = longint'($signed(rhs_acc));
            case (op_seen)
                OP_ADD: calc = lhs_acc + rhs_acc;
                OP_SUB: calc = lhs_acc - rhs_acc;
                OP_MUL: begin
                    prod = sa * sb;
                    if (prod > PROD_MAX || prod < PROD_MIN) wide_seen = 1'b1;
                    calc = 32'(prod);
                end
                default: begin
                    // divisor must be nonzero and leave no remainder
                    if (sb == 0 || (sa % sb) != 0) status = STAT_BAD_DIV;
                    else calc = 32'(sa / sb);
                end
            endcase
            given = ans_neg ? -ans_acc : ans_acc;
            if (status != STAT_BAD_DIV)
                status = (given == calc) ? STAT_CORRECT : STAT_WRONG;
        end

        v.status = status;
        // error verdicts carry nothing but the status
        if (status == STAT_CORRECT || status == STAT_WRONG) begin
            v.left_value      = lhs_acc[30:0];
            v.right_value     = rhs_acc[30:0];
            v.given_answer    = given;
            v.expected_answer = calc;
            v.operator_code   = op_seen;
            v.answer_start    = ans_pos[9:0];
            v.answer_length   = 11'(eq_count - ans_pos);
            v.overflow        = wide_seen;
        end
        clear_parse();
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // String builders
    // ------------------------------------------------------------------
    function automatic text_t str_bytes(input string s);
        text_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // half the time a character the parser cares about, else any byte
    function automatic logic [7:0] pick_char();
        string alphabet;
        alphabet = "0123456789+-*/=";
        if ($urandom_range(1)) return alphabet[$urandom_range(14)];
        return 8'($urandom_range(255));
    endfunction

    // mostly small operands, now and then values up to the full 32 bits
    function automatic logic [31:0] pick_operand();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return $urandom_range(99);
        if (roll < 85) return $urandom_range(9999);
        if (roll < 95) return $urandom_range(999999);
        return $urandom;
    endfunction

    // decimal text, sometimes with leading zeros or extra digits past 32 bits
    function automatic string digits_of(input logic [31:0] v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(9) == 0) s = {"0", s};
        if ($urandom_range(29) == 0) s = {s, $sformatf("%0d", $urandom_range(999))};
        return s;
    endfunction

    function automatic string answer_of(input logic [31:0] v);
        logic [31:0] mag;
        mag = -v;
        if (v[31]) return {"-", $sformatf("%0d", mag)};
        return $sformatf("%0d", v);
    endfunction

    function automatic text_t make_equation();
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        logic [1:0]  op;
        longint      sl;
        longint      sr;
        string       op_text;
        int unsigned roll;
        op  = 2'($urandom_range(3));
        lhs = pick_operand();
        rhs = pick_operand();
        // most divisions are made exact so they reach the compare
        if (op == OP_DIV && $urandom_range(9) < 7) begin
            rhs = $urandom_range(1, 99);
            lhs = rhs * $urandom_range(0, 20000);
        end
        sl = longint'($signed(lhs));
        sr = longint'($signed(rhs));
        case (op)
            OP_ADD: begin
                res = lhs + rhs;
                op_text = "+";
            end
            OP_SUB: begin
                res = lhs - rhs;
                op_text = "-";
            end
            OP_MUL: begin
                res = 32'(sl * sr);
                op_text = "*";
            end
            default: begin
                res = (sr != 0) ? 32'(sl / sr) : '0;
                op_text = "/";
            end
        endcase
        roll = $urandom_range(9);
        if (roll == 6) res = res + $urandom_range(1, 3);
        else if (roll == 7) res = res - 1;
        else if (roll == 8) res = pick_operand();
        else if (roll == 9) res = -res;
        return str_bytes({digits_of(lhs), op_text, digits_of(rhs), "=", answer_of(res)});
    endfunction

    // an equation with one character replaced, inserted, or the tail cut off
    function automatic text_t make_broken();
        text_t t;
        int    pos;
        t   = make_equation();
        pos = $urandom_range(t.size() - 1);
        case ($urandom_range(2))
            0:       t[pos] = pick_char();
            1:       t = t[0:pos];
            default: t.insert(pos, pick_char());
        endcase
        return t;
    endfunction

    function automatic text_t make_random_text();
        text_t       t;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return make_equation();
        if (roll < 90) return make_broken();
        repeat ($urandom_range(1, 9)) t.push_back(pick_char());
        return t;
    endfunction

    function automatic verdict_t fault_verdict(input logic [3:0] code);
        verdict_t v;
        v = '0;
        v.status = code;
        return v;
    endfunction

    function automatic void add_case(input string text, input bit typed, input verdict_t v);
        case_row_t row;
        row.text    = text;
        row.typed   = typed;
        row.verdict = v;
        dir_cases.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // One character request. Valid drops only during a bubble, so it never gets
    // two assignments in the same step.
    task automatic send_req(input symbol_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    // Sends a whole string; a typed row replaces the predicted verdict.
    task automatic send_text(input text_t t, input bit typed, input verdict_t given_verdict);
        symbol_req_t r;
        verdict_t    v;
        for (int i = 0; i < t.size(); i++) begin
            r.symbol      = t[i];
            r.last_symbol = (i == t.size() - 1);
            send_req(r);
            if (judge_symbol(r, v)) verdicts_due.push_back(typed ? given_verdict : v);
        end
        strings_sent++;
    endtask

    // Sender holds off until every predicted verdict has been checked.
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts_due.size() != 0);
    endtask

    task automatic run_random(input int count);
        int target;
        target = chars_sent + count;
        while (chars_sent < target) send_text(make_random_text(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, and the verdict check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic note_fault(input string what);
        if (fault_count < SHOW_FAULTS) $display("ERROR @%0t: %s", $realtime, what);
        fault_count++;
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            verdicts_seen++;
            status_hits[m_data.status]++;
            if (verdicts_due.size() == 0) begin
                note_fault($sformatf("verdict with none pending, status %0d", m_data.status));
            end else begin
                want = verdicts_due.pop_front();
                if (m_data.status !== want.status
                    || m_data.left_value !== want.left_value
                    || m_data.right_value !== want.right_value
                    || m_data.given_answer !== want.given_answer
                    || m_data.expected_answer !== want.expected_answer
                    || m_data.operator_code !== want.operator_code
                    || m_data.answer_start !== want.answer_start
                    || m_data.answer_length !== want.answer_length
                    || m_data.overflow !== want.overflow) begin
                    note_fault($sformatf({"verdict %0d (exp/act): status %0d/%0d ",
                        "left %0d/%0d right %0d/%0d given %0d/%0d calc %0d/%0d ",
                        "op %0d/%0d start %0d/%0d len %0d/%0d ovf %0d/%0d"},
                        verdicts_seen,
                        want.status, m_data.status,
                        want.left_value, m_data.left_value,
                        want.right_value, m_data.right_value,
                        want.given_answer, m_data.given_answer,
                        want.expected_answer, m_data.expected_answer,
                        want.operator_code, m_data.operator_code,
                        want.answer_start, m_data.answer_start,
                        want.answer_length, m_data.answer_length,
                        want.overflow, m_data.overflow));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: no progress after %0d cycles, %0d verdicts pending",
                     cycle_count, verdicts_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        verdict_t zero_sum;
        string    pad;
        string    mix;

        clear_parse();
        foreach (status_hits[i]) status_hits[i] = 0;

        // "0+0=0": every field is readable straight off the string
        zero_sum               = '0;
        zero_sum.status        = STAT_CORRECT;
        zero_sum.operator_code = OP_ADD;
        zero_sum.answer_start  = 10'd4;
        zero_sum.answer_length = 11'd1;

        // short strings: the short verdict wins over parse errors; five characters pass
        add_case("+",       1'b1, fault_verdict(STAT_SHORT));
        add_case("1+1=",    1'b1, fault_verdict(STAT_SHORT));
        add_case("0+0=0",   1'b1, zero_sum);
        // one of each operator answered right, and one wrong sum
        add_case("12+34=46", 1'b0, '0);
        add_case("9-12=-3",  1'b0, '0);
        add_case("6*7=42",   1'b0, '0);
        add_case("84/4=21",  1'b0, '0);
        add_case("1+1=3",    1'b0, '0);
        // each error kind; the first error met is the one reported
        add_case("\377+1=1", 1'b1, fault_verdict(STAT_BAD_LEFT));
        add_case("x+y=z",    1'b1, fault_verdict(STAT_BAD_LEFT));
        add_case("12?3=1",   1'b1, fault_verdict(STAT_BAD_OP));
        add_case("1+x=1",    1'b1, fault_verdict(STAT_BAD_RIGHT));
        add_case("1+2x3",    1'b1, fault_verdict(STAT_BAD_EQ));
        add_case("1+1=x",    1'b1, fault_verdict(STAT_BAD_ANS));
        add_case("1+1=-x",   1'b1, fault_verdict(STAT_BAD_ANS));
        add_case("1+1=2x",   1'b1, fault_verdict(STAT_BAD_TAIL));
        add_case("7/0=0",    1'b1, fault_verdict(STAT_BAD_DIV));
        add_case("7/2=3",    1'b1, fault_verdict(STAT_BAD_DIV));
        // string ends while something is still missing
        add_case("12345",    1'b1, fault_verdict(STAT_BAD_OP));
        add_case("1234+",    1'b1, fault_verdict(STAT_BAD_RIGHT));
        add_case("12+34",    1'b1, fault_verdict(STAT_BAD_EQ));
        add_case("12+3=",    1'b1, fault_verdict(STAT_BAD_ANS));
        add_case("1+2=-",    1'b1, fault_verdict(STAT_BAD_ANS));
        // operands past int32: wrapped accumulators, product overflow, MIN / -1
        add_case("4294967295+1=0",                     1'b0, '0);
        add_case("65536*65536=0",                      1'b0, '0);
        add_case("2147483648/4294967295=-2147483648",  1'b0, '0);
        // long strings: count saturates, start and length get masked
        pad = "";
        repeat (1100) pad = {pad, "0"};
        add_case({"1+1=", pad, "2"}, 1'b0, '0);
        add_case({pad, "1+1=2"},     1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_cases[i])
            send_text(str_bytes(dir_cases[i].text), dir_cases[i].typed, dir_cases[i].verdict);
        drain_verdicts();

        // random: bubbles on both sides, then a stretch at full rate,
        // a full drain, and bubbles again
        run_random(500);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(350);
        send_idle_pct = 37;
        stall_pct     = 37;
        drain_verdicts();
        run_random(RANDOM_CHARS - 850);

        drain_verdicts();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        mix = "";
        for (int i = 0; i <= STAT_BAD_DIV; i++) mix = {mix, $sformatf(" %0d", status_hits[i])};
        $display("Sent %0d strings (%0d characters), checked %0d verdicts in %0d cycles.",
                 strings_sent, chars_sent, verdicts_seen, cycle_count);
        $display("Verdicts by status, correct through bad division:%s", mix);
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fault_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
